// ----- rtl/astok_pkg.sv -----
`default_nettype none

package astok_pkg;

	// Field widths of one result.
	localparam int ROW_BITS   = 16;
	localparam int COL_BITS   = 12;
	localparam int VALUE_BITS = 32;
	localparam int KIND_BITS  = 3;
	localparam int CHAR_BITS  = 8;

	// Stream widths: tdata is padded to whole bytes.
	localparam int IN_DATA_W  = 8;
	localparam int IN_USER_W  = 1;
	localparam int OUT_DATA_W = ((VALUE_BITS + ROW_BITS + COL_BITS + 7) / 8) * 8;
	localparam int OUT_USER_W = KIND_BITS + 1;

	// Result queue.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int CNT_W      = 3;

	// Character codes.
	localparam logic [CHAR_BITS-1:0] CH_LF        = 8'h0A;
	localparam logic [CHAR_BITS-1:0] CH_SEMI      = 8'h3B;
	localparam logic [CHAR_BITS-1:0] CH_ZERO      = 8'h30;
	localparam logic [CHAR_BITS-1:0] CH_ONE       = 8'h31;
	localparam logic [CHAR_BITS-1:0] CH_NINE      = 8'h39;
	localparam logic [CHAR_BITS-1:0] CH_MINUS     = 8'h2D;
	localparam logic [CHAR_BITS-1:0] CH_QUOTE     = 8'h27;
	localparam logic [CHAR_BITS-1:0] CH_BACKSLASH = 8'h5C;
	localparam logic [CHAR_BITS-1:0] CH_LOWER_X   = 8'h78;
	localparam logic [CHAR_BITS-1:0] CH_LOWER_B   = 8'h62;
	localparam logic [CHAR_BITS-1:0] CH_LOWER_N   = 8'h6E;
	localparam logic [CHAR_BITS-1:0] CH_LOWER_T   = 8'h74;
	localparam logic [CHAR_BITS-1:0] CH_LOWER_R   = 8'h72;
	localparam logic [CHAR_BITS-1:0] CH_LOWER_V   = 8'h76;

	// Error codes carried in the value field of an error result.
	localparam logic [VALUE_BITS-1:0] ERR_LONE_BACKSLASH = 32'd0;
	localparam logic [VALUE_BITS-1:0] ERR_BAD_ESCAPE     = 32'd1;

	localparam logic [35:0] NUM_LIMIT = 36'h0_8000_0000;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_NUMBER     = 3'd0,
		KIND_SPECIAL    = 3'd1,
		KIND_CHAR       = 3'd2,
		KIND_IDENT_CHAR = 3'd3,
		KIND_IDENT_END  = 3'd4,
		KIND_ERROR      = 3'd5
	} kind_t;

	typedef enum logic [7:0] {
		MODE_IDLE    = 8'b0000_0001,
		MODE_COMMENT = 8'b0000_0010,
		MODE_DEC     = 8'b0000_0100,
		MODE_ZERO    = 8'b0000_1000,
		MODE_HEX     = 8'b0001_0000,
		MODE_BIN     = 8'b0010_0000,
		MODE_IDENT   = 8'b0100_0000,
		MODE_LIT     = 8'b1000_0000
	} mode_t;

	typedef struct packed {
		kind_t                  kind;
		logic [VALUE_BITS-1:0]  value;
		logic [ROW_BITS-1:0]    row;
		logic [COL_BITS-1:0]    column;
		logic                   token_start;
	} result_t;

	// What the scanner hands to the result queue for one step.
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
		logic       err;
	} lex_step_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] d;
	} digit_t;

	typedef struct packed {
		kind_t                 kind;
		logic [VALUE_BITS-1:0] value;
		logic                  err;
	} lit_res_t;

	function automatic logic is_space(input logic [CHAR_BITS-1:0] c);
		return c inside {8'h20, [8'h09:8'h0D], 8'h85, 8'hA0};
	endfunction

	function automatic logic is_special(input logic [CHAR_BITS-1:0] c);
		return c inside {8'h3A, 8'h23, 8'h26};
	endfunction

	function automatic digit_t hex_digit(input logic [CHAR_BITS-1:0] c);
		digit_t r;
		r.ok = 1'b1;
		r.d  = 4'd0;
		if (c inside {[8'h30:8'h39]}) begin
			r.d = 4'(c - 8'h30);
		end else if (c inside {[8'h41:8'h46]}) begin
			r.d = 4'(c - 8'h37);
		end else if (c inside {[8'h61:8'h66]}) begin
			r.d = 4'(c - 8'h57);
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

	// Out-of-range magnitudes read as zero; the bare magnitude 2^31 is legal only negated.
	function automatic logic [VALUE_BITS-1:0] number_word(input logic [VALUE_BITS-1:0] nv,
			input logic ovf, input logic neg);
		logic [VALUE_BITS-1:0] r;
		r = '0;
		if (!ovf) begin
			if (neg) begin
				r = '0 - nv;
			end else if (nv != 32'h8000_0000) begin
				r = nv;
			end
		end
		return r;
	endfunction

	function automatic lit_res_t finish_literal(input logic [1:0] len,
			input logic [CHAR_BITS-1:0] a, input logic [CHAR_BITS-1:0] b);
		lit_res_t r;
		r.kind  = KIND_ERROR;
		r.value = ERR_BAD_ESCAPE;
		r.err   = 1'b1;
		if (len == 2'd1) begin
			if (a == CH_BACKSLASH) begin
				r.value = ERR_LONE_BACKSLASH;
			end else begin
				r.kind  = KIND_CHAR;
				r.value = VALUE_BITS'(a);
				r.err   = 1'b0;
			end
		end else if (len == 2'd2 && a == CH_BACKSLASH) begin
			r.kind = KIND_CHAR;
			r.err  = 1'b0;
			case (b)
				CH_LOWER_N: r.value = 32'd10;
				CH_LOWER_T: r.value = 32'd9;
				CH_ZERO:    r.value = 32'd0;
				CH_LOWER_R: r.value = 32'd13;
				CH_LOWER_V: r.value = 32'd11;
				default: begin
					r.kind  = KIND_ERROR;
					r.value = ERR_BAD_ESCAPE;
					r.err   = 1'b1;
				end
			endcase
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/astok_core.sv -----
`default_nettype none

// Scanner state and the per-byte update; results of a step are valid while step is high.
module astok_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             step,
	input  wire logic [astok_pkg::CHAR_BITS-1:0]  ch,
	input  wire logic                             flush,
	output astok_pkg::lex_step_t                  res
);

	astok_pkg::mode_t                         mode_q, mode_n;
	logic [astok_pkg::VALUE_BITS-1:0]         nv_q, nv_n;
	logic                                     ovf_q, ovf_n;
	logic                                     neg_q, neg_n;
	logic [astok_pkg::ROW_BITS-1:0]           row_q, row_n;
	logic [astok_pkg::COL_BITS-1:0]           col_q, col_n;
	logic [astok_pkg::COL_BITS-1:0]           tcol_q, tcol_n;
	logic [astok_pkg::CHAR_BITS-1:0]          lit0_q, lit0_n, lit1_q, lit1_n;
	logic [1:0]                               len_q, len_n;
	logic                                     err_q, err_n;

	// Token finish.
	logic                 fin_valid, fin_err;
	astok_pkg::result_t   fin_res;
	astok_pkg::lit_res_t  lit;

	// Token start.
	astok_pkg::mode_t                  st_mode;
	logic                              st_emit, st_neg, st_lit;
	logic [astok_pkg::VALUE_BITS-1:0]  st_nv;
	astok_pkg::result_t                st_res;

	// Digit accumulation.
	astok_pkg::digit_t  dig;
	logic               dig_ok;
	logic [35:0]        acc_mul, acc_sum;
	logic [astok_pkg::VALUE_BITS-1:0] acc_nv;
	logic               acc_ovf;

	logic               a_valid, b_valid, do_start;
	astok_pkg::result_t a_res;

	always_comb begin
		lit       = astok_pkg::finish_literal(len_q, lit0_q, lit1_q);
		fin_valid = 1'b0;
		fin_err   = 1'b0;
		fin_res   = '{kind: astok_pkg::KIND_NUMBER,
			value: astok_pkg::number_word(nv_q, ovf_q, neg_q),
			row: row_q, column: tcol_q, token_start: 1'b0};
		case (mode_q)
			astok_pkg::MODE_DEC, astok_pkg::MODE_ZERO, astok_pkg::MODE_HEX,
			astok_pkg::MODE_BIN: begin
				fin_valid = 1'b1;
			end
			astok_pkg::MODE_IDENT: begin
				fin_valid     = 1'b1;
				fin_res.kind  = astok_pkg::KIND_IDENT_END;
				fin_res.value = '0;
			end
			astok_pkg::MODE_LIT: begin
				fin_valid     = 1'b1;
				fin_res.kind  = lit.kind;
				fin_res.value = lit.value;
				fin_err       = lit.err;
			end
			default: ;
		endcase
	end

	always_comb begin
		st_mode = astok_pkg::MODE_IDENT;
		st_emit = 1'b0;
		st_neg  = 1'b0;
		st_lit  = 1'b0;
		st_nv   = '0;
		st_res  = '{kind: astok_pkg::KIND_IDENT_CHAR,
			value: astok_pkg::VALUE_BITS'(ch), row: row_q, column: col_q, token_start: 1'b1};
		if (astok_pkg::is_space(ch)) begin
			st_mode = astok_pkg::MODE_IDLE;
		end else if (ch == astok_pkg::CH_SEMI) begin
			st_mode = astok_pkg::MODE_COMMENT;
		end else if (ch == astok_pkg::CH_ZERO) begin
			st_mode = astok_pkg::MODE_ZERO;
		end else if (ch == astok_pkg::CH_MINUS) begin
			st_mode = astok_pkg::MODE_DEC;
			st_neg  = 1'b1;
		end else if (ch >= astok_pkg::CH_ONE && ch <= astok_pkg::CH_NINE) begin
			st_mode = astok_pkg::MODE_DEC;
			st_nv   = astok_pkg::VALUE_BITS'(ch - astok_pkg::CH_ZERO);
		end else if (astok_pkg::is_special(ch)) begin
			st_mode            = astok_pkg::MODE_IDLE;
			st_emit            = 1'b1;
			st_res.kind        = astok_pkg::KIND_SPECIAL;
			st_res.token_start = 1'b0;
		end else if (ch == astok_pkg::CH_QUOTE) begin
			st_mode = astok_pkg::MODE_LIT;
			st_lit  = 1'b1;
		end else begin
			st_emit = 1'b1;
		end
	end

	// One multiply-add by a constant base: shifts and an adder, plus one more for base ten.
	always_comb begin
		dig = astok_pkg::hex_digit(ch);
		case (mode_q)
			astok_pkg::MODE_HEX: begin
				dig_ok  = dig.ok;
				acc_mul = {nv_q, 4'b0000};
			end
			astok_pkg::MODE_BIN: begin
				dig_ok  = dig.ok && dig.d < 4'd2;
				acc_mul = {3'b000, nv_q, 1'b0};
			end
			default: begin
				dig_ok  = dig.ok && dig.d < 4'd10;
				acc_mul = {1'b0, nv_q, 3'b000} + {3'b000, nv_q, 1'b0};
			end
		endcase
		acc_sum = acc_mul + 36'(dig.d);
		acc_nv  = nv_q;
		acc_ovf = ovf_q;
		if (!ovf_q) begin
			if (acc_sum > astok_pkg::NUM_LIMIT) begin
				acc_ovf = 1'b1;
			end else begin
				acc_nv = acc_sum[astok_pkg::VALUE_BITS-1:0];
			end
		end
	end

	always_comb begin
		mode_n   = mode_q;
		nv_n     = nv_q;
		ovf_n    = ovf_q;
		neg_n    = neg_q;
		row_n    = row_q;
		col_n    = col_q;
		tcol_n   = tcol_q;
		lit0_n   = lit0_q;
		lit1_n   = lit1_q;
		len_n    = len_q;
		err_n    = err_q;
		a_valid  = 1'b0;
		b_valid  = 1'b0;
		do_start = 1'b0;
		a_res    = fin_res;
		if (flush) begin
			a_valid = fin_valid && !err_q;
			mode_n  = astok_pkg::MODE_IDLE;
			nv_n    = '0;
			ovf_n   = 1'b0;
			neg_n   = 1'b0;
			row_n   = astok_pkg::ROW_BITS'(1);
			col_n   = '0;
			tcol_n  = '0;
			lit0_n  = '0;
			lit1_n  = '0;
			len_n   = '0;
			err_n   = 1'b0;
		end else if (!err_q) begin
			if (ch == astok_pkg::CH_LF) begin
				a_valid = fin_valid;
				err_n   = fin_err;
				mode_n  = astok_pkg::MODE_IDLE;
				col_n   = '0;
				if (row_q != '1) begin
					row_n = row_q + astok_pkg::ROW_BITS'(1);
				end
			end else begin
				case (mode_q)
					astok_pkg::MODE_COMMENT: ;
					astok_pkg::MODE_DEC, astok_pkg::MODE_HEX, astok_pkg::MODE_BIN: begin
						if (dig_ok) begin
							nv_n  = acc_nv;
							ovf_n = acc_ovf;
						end else begin
							a_valid  = 1'b1;
							do_start = 1'b1;
						end
					end
					astok_pkg::MODE_ZERO: begin
						if (ch == astok_pkg::CH_LOWER_X) begin
							mode_n = astok_pkg::MODE_HEX;
						end else if (ch == astok_pkg::CH_LOWER_B) begin
							mode_n = astok_pkg::MODE_BIN;
						end else if (dig_ok) begin
							mode_n = astok_pkg::MODE_DEC;
							nv_n   = acc_nv;
							ovf_n  = acc_ovf;
						end else begin
							a_valid  = 1'b1;
							do_start = 1'b1;
						end
					end
					astok_pkg::MODE_IDENT: begin
						a_valid = 1'b1;
						if (astok_pkg::is_space(ch)) begin
							mode_n = astok_pkg::MODE_IDLE;
						end else if (astok_pkg::is_special(ch)) begin
							do_start = 1'b1;
						end else begin
							a_res.kind  = astok_pkg::KIND_IDENT_CHAR;
							a_res.value = astok_pkg::VALUE_BITS'(ch);
						end
					end
					astok_pkg::MODE_LIT: begin
						if (ch == astok_pkg::CH_QUOTE) begin
							a_valid = 1'b1;
							err_n   = fin_err;
							mode_n  = astok_pkg::MODE_IDLE;
						end else begin
							if (len_q == 2'd0) begin
								lit0_n = ch;
							end else if (len_q == 2'd1) begin
								lit1_n = ch;
							end
							if (len_q != 2'd3) begin
								len_n = len_q + 2'd1;
							end
						end
					end
					default: begin
						do_start = 1'b1;
					end
				endcase
				if (col_q != '1) begin
					col_n = col_q + astok_pkg::COL_BITS'(1);
				end
				if (do_start) begin
					tcol_n  = col_q;
					nv_n    = st_nv;
					ovf_n   = 1'b0;
					neg_n   = st_neg;
					mode_n  = st_mode;
					b_valid = st_emit;
					if (st_lit) begin
						len_n  = '0;
						lit0_n = '0;
						lit1_n = '0;
					end
				end
			end
		end
	end

	always_comb begin
		res.count  = {1'b0, a_valid} + {1'b0, b_valid};
		res.first  = a_valid ? a_res : st_res;
		res.second = st_res;
		res.err    = err_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= astok_pkg::MODE_IDLE;
			nv_q   <= '0;
			ovf_q  <= 1'b0;
			neg_q  <= 1'b0;
			row_q  <= astok_pkg::ROW_BITS'(1);
			col_q  <= '0;
			tcol_q <= '0;
			lit0_q <= '0;
			lit1_q <= '0;
			len_q  <= '0;
			err_q  <= 1'b0;
		end else if (step) begin
			mode_q <= mode_n;
			nv_q   <= nv_n;
			ovf_q  <= ovf_n;
			neg_q  <= neg_n;
			row_q  <= row_n;
			col_q  <= col_n;
			tcol_q <= tcol_n;
			lit0_q <= lit0_n;
			lit1_q <= lit1_n;
			len_q  <= len_n;
			err_q  <= err_n;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/assembly_source_tokenizer_unit.sv -----
// A byte's results enter the result queue at its transfer; the master side offers them.
// Throughput: one byte per cycle while ready; a byte that causes two results needs two
// output transfers, and a four-entry result queue lets input continue while those drain.
// The slave side is ready while at least two queue entries are free.
// Reset: arst_n clears the scanner to row 1, column 0, idle, and empties the result queue.
`default_nettype none

module assembly_source_tokenizer_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// Slave side: one source byte per transfer.
	input  wire logic                               s_tvalid,
	output      logic                               s_tready,
	input  wire logic [astok_pkg::IN_DATA_W-1:0]    s_tdata,  // [7:0] ch
	input  wire logic [astok_pkg::IN_USER_W-1:0]    s_tuser,  // [0] flush
	// Master side: one token result per transfer.
	output      logic                               m_tvalid,
	input  wire logic                               m_tready,
	output      logic [astok_pkg::OUT_DATA_W-1:0]   m_tdata,  // value, row, column, zero pad
	output      logic [astok_pkg::OUT_USER_W-1:0]   m_tuser,  // kind, token_start
	output      logic                               m_tlast
);

	// One queue entry is a result and its end-of-step mark.
	typedef struct packed {
		astok_pkg::result_t res;
		logic               last;
	} entry_t;

	localparam logic [astok_pkg::CNT_W-1:0] READY_MAX =
		astok_pkg::CNT_W'(astok_pkg::FIFO_DEPTH - 2);

	logic                               s_acc, m_acc;
	astok_pkg::lex_step_t               lex;
	logic [1:0]                         push_n;
	entry_t                             fifo_q [astok_pkg::FIFO_DEPTH];
	logic [astok_pkg::FIFO_AW-1:0]      wr_q, rd_q;
	logic [astok_pkg::CNT_W-1:0]        cnt_q;
	entry_t                             head;

	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid && m_tready;

	// The scanner updates its state on every accepted transfer and reports the
	// zero, one or two results that the byte completes.
	astok_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (s_acc),
		.ch     (s_tdata[astok_pkg::CHAR_BITS-1:0]),
		.flush  (s_tuser[0]),
		.res    (lex)
	);

	assign push_n = s_acc ? lex.count : 2'd0;

	// Results of one step are written in order; the last of them carries tlast.
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			fifo_q[wr_q] <= '{res: lex.first, last: (push_n == 2'd1)};
		end
		if (push_n == 2'd2) begin
			fifo_q[wr_q + astok_pkg::FIFO_AW'(1)] <= '{res: lex.second, last: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + astok_pkg::FIFO_AW'(push_n);
			rd_q  <= rd_q + astok_pkg::FIFO_AW'(m_acc);
			cnt_q <= cnt_q + astok_pkg::CNT_W'(push_n) - astok_pkg::CNT_W'(m_acc);
		end
	end

	// Room for the worst case of two results keeps a byte from ever being half stored.
	assign s_tready = cnt_q <= READY_MAX;

	assign head     = fifo_q[rd_q];
	assign m_tvalid = cnt_q != '0;
	assign m_tdata  = astok_pkg::OUT_DATA_W'({head.res.column, head.res.row, head.res.value});
	assign m_tuser  = {head.res.token_start, head.res.kind};
	assign m_tlast  = head.last;

`ifndef SYNTHESIS
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= astok_pkg::CNT_W'(astok_pkg::FIFO_DEPTH))
		else $error("result queue holds more entries than it has");

	a_error_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && lex.err && !s_tuser[0]) |-> (lex.count == 2'd0))
		else $error("a result was produced while an error is latched");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && s_tuser[0]) |=> !lex.err)
		else $error("flush did not clear the error latch");

	a_tlast_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && lex.count == 2'd1 && cnt_q == '0) |=> (m_tvalid && m_tlast))
		else $error("single result of a step not marked as last");
`endif

endmodule

`default_nettype wire
